// ----- design/deadband_pid_joint_drive_top_macros.svh -----
// ----------------------------------------------------------------------------
// deadband_pid_joint_drive_top_macros.svh
// Assertion macros for the joint drive checker.
// ----------------------------------------------------------------------------
`ifndef DEADBAND_PID_JOINT_DRIVE_TOP_MACROS_SVH
`define DEADBAND_PID_JOINT_DRIVE_TOP_MACROS_SVH

// Clocked property, held off while reset is high.
`define DPJD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define DPJD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/dpjd_pkg.sv -----
// ----------------------------------------------------------------------------
// dpjd_pkg
// Types and constants for the deadband PID joint drive.
// ----------------------------------------------------------------------------
package dpjd_pkg;

  localparam int SAMPLE_W = 10;
  localparam int GAIN_W   = 12;
  localparam int BAND_W   = 10;
  localparam int ERR_W    = 11;
  localparam int DUTY_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int SUM_WIDTH_DEF = 32;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 12'd768;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 12'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 12'd26;
  localparam logic [BAND_W-1:0] DEAD_BAND_RST  = 10'd20;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  // Any |sum| beyond 2^16 saturates the duty for every nonzero gain.
  localparam int               ISUM_W     = 17;
  localparam logic [ISUM_W-1:0] ISUM_CLAMP = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_DERIV_GAIN = 2'd2,
    CFG_DEAD_BAND  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [BAND_W-1:0] dead_band;
  } dpjd_cfg_t;

  typedef struct packed {
    logic                     drive_forward;
    logic                     drive_reverse;
    logic [DUTY_W-1:0]        duty;
    logic signed [ERR_W-1:0]  position_error;
  } dpjd_result_t;

endpackage

// ----- design/dpjd_terms.sv -----
// ----------------------------------------------------------------------------
// dpjd_terms
// Error, direction, PID duty and next running sum for one sample pair.
// ----------------------------------------------------------------------------
module dpjd_terms #(
  parameter int SUM_WIDTH = dpjd_pkg::SUM_WIDTH_DEF
) (
  input  dpjd_pkg::dpjd_cfg_t                    cfg,
  input  logic [dpjd_pkg::SAMPLE_W-1:0]          master_sample,
  input  logic [dpjd_pkg::SAMPLE_W-1:0]          slave_sample,
  input  logic signed [dpjd_pkg::ERR_W-1:0]      last_error,
  input  logic signed [SUM_WIDTH-1:0]            error_sum,
  output dpjd_pkg::dpjd_result_t                 result,
  output logic signed [SUM_WIDTH-1:0]            error_sum_next
);
  import dpjd_pkg::*;

  localparam int EXT_W = (SUM_WIDTH > ISUM_W) ? SUM_WIDTH : ISUM_W;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   band_s;
  logic [SAMPLE_W-1:0]       err_mag;
  logic signed [ERR_W:0]     diff;
  logic [ERR_W-1:0]          diff_mag;
  logic [SUM_WIDTH-1:0]      sum_mag;
  logic [EXT_W-1:0]          sum_mag_ext;
  logic [ISUM_W-1:0]         isum;
  logic [GAIN_W+SAMPLE_W-1:0] p_prod;
  logic [GAIN_W+ISUM_W-1:0]   i_prod;
  logic [GAIN_W+ERR_W-1:0]    d_prod;
  logic [GAIN_W+ISUM_W-1:0]   total;
  logic signed [SUM_WIDTH:0] sum_wide;

  always_comb begin
    err    = ERR_W'($signed({1'b0, master_sample}) - $signed({1'b0, slave_sample}));
    band_s = $signed({1'b0, cfg.dead_band});

    err_mag  = err[ERR_W-1] ? SAMPLE_W'(-err) : err[SAMPLE_W-1:0];
    diff     = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
    diff_mag = diff[ERR_W] ? ERR_W'(-diff) : diff[ERR_W-1:0];

    sum_mag     = error_sum[SUM_WIDTH-1] ? (~error_sum + 1'b1) : error_sum;
    sum_mag_ext = EXT_W'(sum_mag);
    isum        = (sum_mag_ext > EXT_W'(ISUM_CLAMP)) ? ISUM_CLAMP : sum_mag_ext[ISUM_W-1:0];

    p_prod = cfg.prop_gain * err_mag;
    i_prod = cfg.integral_gain * isum;
    d_prod = cfg.deriv_gain * diff_mag;

    // Each term is truncated on its own before the sum.
    total = (GAIN_W+ISUM_W)'(p_prod[GAIN_W+SAMPLE_W-1:8])
          + (GAIN_W+ISUM_W)'(i_prod[GAIN_W+ISUM_W-1:8])
          + (GAIN_W+ISUM_W)'(d_prod[GAIN_W+ERR_W-1:8]);

    result.drive_forward  = err > band_s;
    result.drive_reverse  = err < -band_s;
    result.duty           = (total > (GAIN_W+ISUM_W)'(DUTY_MAX)) ? DUTY_MAX
                                                                 : total[DUTY_W-1:0];
    result.position_error = err;

    sum_wide = {error_sum[SUM_WIDTH-1], error_sum}
             + {{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      // overflow: clamp to the signed range
      error_sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[SUM_WIDTH-1:0];
    end
  end

endmodule

// ----- design/deadband_pid_joint_drive_top.sv -----
// ----------------------------------------------------------------------------
// deadband_pid_joint_drive_top
// One master/slave joint channel: deadband direction and PID duty per sample.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall   master_sample, slave_sample
// out       source     out_valid / out_stall drive_forward, drive_reverse, duty,
//                                            position_error
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample pair per cycle while the output is not stalled; each pair passes the
// input register, then the result register, via one step through the three gain
// multipliers and the running-sum update, which must close before the next item.
// Synchronous reset restores the gains, dead band, last error and sum.
// A stalled result holds; an empty input register takes one more transfer,
// then in_stall stays high until the result leaves.
// ----------------------------------------------------------------------------
module deadband_pid_joint_drive_top #(
  parameter int SUM_WIDTH = dpjd_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dpjd_pkg::SAMPLE_W-1:0]       master_sample,
  input  logic [dpjd_pkg::SAMPLE_W-1:0]       slave_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                drive_forward,
  output logic                                drive_reverse,
  output logic [dpjd_pkg::DUTY_W-1:0]         duty,
  output logic signed [dpjd_pkg::ERR_W-1:0]   position_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpjd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpjd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dpjd_pkg::*;

  dpjd_cfg_t               cfg;
  logic                    s1_valid;
  logic [SAMPLE_W-1:0]     s1_master;
  logic [SAMPLE_W-1:0]     s1_slave;
  logic signed [ERR_W-1:0] last_error;
  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [SUM_WIDTH-1:0] error_sum_next;
  dpjd_result_t            result_next;
  logic                    advance;
  logic                    in_xfer;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  dpjd_terms #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_terms (
    .cfg            (cfg),
    .master_sample  (s1_master),
    .slave_sample   (s1_slave),
    .last_error     (last_error),
    .error_sum      (error_sum),
    .result         (result_next),
    .error_sum_next (error_sum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      out_valid          <= 1'b0;
      last_error         <= '0;
      error_sum          <= '0;
      cfg.prop_gain      <= PROP_GAIN_RST;
      cfg.integral_gain  <= INTEG_GAIN_RST;
      cfg.deriv_gain     <= DERIV_GAIN_RST;
      cfg.dead_band      <= DEAD_BAND_RST;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (advance && s1_valid) begin
        last_error <= result_next.position_error;
        error_sum  <= error_sum_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_PROP_GAIN:  cfg.prop_gain     <= cfg_data[GAIN_W-1:0];
          CFG_INTEG_GAIN: cfg.integral_gain <= cfg_data[GAIN_W-1:0];
          CFG_DERIV_GAIN: cfg.deriv_gain    <= cfg_data[GAIN_W-1:0];
          CFG_DEAD_BAND:  cfg.dead_band     <= cfg_data[BAND_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_master <= master_sample;
      s1_slave  <= slave_sample;
    end
    if (advance && s1_valid) begin
      drive_forward  <= result_next.drive_forward;
      drive_reverse  <= result_next.drive_reverse;
      duty           <= result_next.duty;
      position_error <= result_next.position_error;
    end
  end

endmodule

// ----- design/dpjd_checker.sv -----
// ----------------------------------------------------------------------------
// dpjd_checker
// Port-level checks on the joint drive, bound to the top level.
// ----------------------------------------------------------------------------
`include "deadband_pid_joint_drive_top_macros.svh"

module dpjd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                drive_forward,
  input logic                                drive_reverse,
  input logic [dpjd_pkg::DUTY_W-1:0]         duty,
  input logic signed [dpjd_pkg::ERR_W-1:0]   position_error
);
  import dpjd_pkg::*;

  logic out_held;
  logic err_neg;
  logic err_zero;

  assign out_held = out_valid && out_stall;
  assign err_neg  = position_error[ERR_W-1];
  assign err_zero = (position_error == '0);

  // a stalled result transfer keeps its duty and position error
  `DPJD_ASSERT(a_out_hold, clk, rst, out_held |=> out_valid && $stable({duty, position_error}), "stalled result changed")

  `DPJD_ASSERT(a_dir_excl, clk, rst, out_valid |-> !(drive_forward && drive_reverse), "both lines high")

  // direction must agree with the error sign
  `DPJD_ASSERT(a_fwd_sign, clk, rst, out_valid && drive_forward |-> !err_neg && !err_zero, "bad forward")

  `DPJD_ASSERT(a_rev_sign, clk, rst, out_valid && drive_reverse |-> err_neg, "bad reverse")

  `DPJD_ASSERT_ALWAYS(a_rst_empty, clk, $past(rst) |-> !out_valid, "valid after reset")

endmodule

bind deadband_pid_joint_drive_top dpjd_checker u_dpjd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .drive_forward  (drive_forward),
  .drive_reverse  (drive_reverse),
  .duty           (duty),
  .position_error (position_error)
);
